FILE: hdl/d7s_pkg.sv
// Shared types, constants and the segment lookup for the decimal to seven-segment writer.
package d7s_pkg;

	localparam int unsigned ValueWidth = 16;
	localparam int unsigned DigitCount = 5;
	localparam int unsigned BcdWidth = 4 * DigitCount;
	localparam int unsigned StepCountWidth = 4;
	localparam logic [StepCountWidth-1:0] LastStep = 4'd15;

	localparam logic [7:0] SegMinus = 8'b01000000;
	localparam logic [7:0] SegBlank = 8'b00000000;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_SIZE,
		ST_EMIT
	} state_t;

	function automatic logic [7:0] digit_segments(input logic [3:0] digit);
		logic [7:0] seg;
		case (digit)
			4'd0: seg = 8'b00111111;
			4'd1: seg = 8'b00000110;
			4'd2: seg = 8'b01011011;
			4'd3: seg = 8'b01001111;
			4'd4: seg = 8'b01100110;
			4'd5: seg = 8'b01101101;
			4'd6: seg = 8'b01111101;
			4'd7: seg = 8'b00000111;
			4'd8: seg = 8'b01111111;
			4'd9: seg = 8'b01101111;
			default: seg = SegBlank;
		endcase
		return seg;
	endfunction

endpackage

FILE: hdl/d7s_dabble_step.sv
// One shift-and-add-3 step of the binary to BCD conversion.
module d7s_dabble_step (
	input  logic [d7s_pkg::ValueWidth-1:0] bin,
	input  logic [d7s_pkg::BcdWidth-1:0]   bcd,
	output logic [d7s_pkg::ValueWidth-1:0] bin_next,
	output logic [d7s_pkg::BcdWidth-1:0]   bcd_next
);

	logic [d7s_pkg::BcdWidth-1:0] adjusted;

	always_comb begin
		for (int i = 0; i < d7s_pkg::DigitCount; i++) begin
			if (bcd[4*i +: 4] >= 4'd5) begin
				adjusted[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
			end else begin
				adjusted[4*i +: 4] = bcd[4*i +: 4];
			end
		end
	end

	assign bcd_next = {adjusted[d7s_pkg::BcdWidth-2:0], bin[d7s_pkg::ValueWidth-1]};
	assign bin_next = {bin[d7s_pkg::ValueWidth-2:0], 1'b0};

endmodule

FILE: hdl/decimal_to_seven_segment.sv
// Top level: converts a number to decimal and emits its seven-segment characters one per cycle.
// A request runs through 16 iterations of the shared shift-and-add-3 unit, a sizing state and then
// the emit state for n = 1 to 6 characters; the next request is accepted only after its final one.
// The receiver cannot stall; busy falls as the final character is registered.
// Reset clears the sequencer and the strobe; no request is in flight after reset.
module decimal_to_seven_segment (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        kind,
	input  logic [15:0] value,
	input  logic [7:0]  start_position,
	output logic        strobe,
	output logic [7:0]  digit_position,
	output logic [7:0]  segment_pattern,
	output logic        last
);

	d7s_pkg::state_t state_q, state_d;
	logic [d7s_pkg::ValueWidth-1:0]     bin_q, bin_d;
	logic [d7s_pkg::BcdWidth-1:0]       bcd_q, bcd_d;
	logic [d7s_pkg::StepCountWidth-1:0] cnt_q, cnt_d;
	logic                               neg_q, neg_d;
	logic [7:0]                         pos_q, pos_d;
	logic [2:0]                         idx_q, idx_d;
	logic                               strobe_q, strobe_d;
	logic [7:0]                         out_pos_q, out_pos_d;
	logic [7:0]                         out_seg_q, out_seg_d;
	logic                               out_last_q, out_last_d;

	logic [d7s_pkg::ValueWidth-1:0] bin_step;
	logic [d7s_pkg::BcdWidth-1:0]   bcd_step;
	logic                           negative;
	logic [2:0]                     top_digit;
	logic [3:0]                     cur_digit;

	d7s_dabble_step u_step (
		.bin      (bin_q),
		.bcd      (bcd_q),
		.bin_next (bin_step),
		.bcd_next (bcd_step)
	);

	assign negative = kind & value[15];
	assign cur_digit = bcd_q[{idx_q, 2'b00} +: 4];

	always_comb begin
		if (bcd_q[19:16] != 4'd0) begin
			top_digit = 3'd4;
		end else if (bcd_q[15:12] != 4'd0) begin
			top_digit = 3'd3;
		end else if (bcd_q[11:8] != 4'd0) begin
			top_digit = 3'd2;
		end else if (bcd_q[7:4] != 4'd0) begin
			top_digit = 3'd1;
		end else begin
			top_digit = 3'd0;
		end
	end

	always_comb begin
		state_d = state_q;
		bin_d = bin_q;
		bcd_d = bcd_q;
		cnt_d = cnt_q;
		neg_d = neg_q;
		pos_d = pos_q;
		idx_d = idx_q;
		strobe_d = 1'b0;
		out_pos_d = out_pos_q;
		out_seg_d = out_seg_q;
		out_last_d = out_last_q;
		case (state_q)
			d7s_pkg::ST_IDLE: begin
				if (start) begin
					bin_d = negative ? (16'd0 - value) : value;
					bcd_d = '0;
					cnt_d = '0;
					neg_d = negative;
					pos_d = start_position;
					state_d = d7s_pkg::ST_CONV;
				end
			end
			d7s_pkg::ST_CONV: begin
				bin_d = bin_step;
				bcd_d = bcd_step;
				cnt_d = cnt_q + 1'b1;
				if (cnt_q == d7s_pkg::LastStep) begin
					state_d = d7s_pkg::ST_SIZE;
				end
			end
			d7s_pkg::ST_SIZE: begin
				idx_d = top_digit;
				state_d = d7s_pkg::ST_EMIT;
			end
			d7s_pkg::ST_EMIT: begin
				strobe_d = 1'b1;
				out_pos_d = pos_q;
				pos_d = pos_q + 8'd1;
				if (neg_q) begin
					out_seg_d = d7s_pkg::SegMinus;
					out_last_d = 1'b0;
					neg_d = 1'b0;
				end else begin
					out_seg_d = d7s_pkg::digit_segments(cur_digit);
					out_last_d = (idx_q == 3'd0);
					if (idx_q == 3'd0) begin
						state_d = d7s_pkg::ST_IDLE;
					end else begin
						idx_d = idx_q - 3'd1;
					end
				end
			end
			default: begin
				state_d = d7s_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= d7s_pkg::ST_IDLE;
			strobe_q <= 1'b0;
		end else begin
			state_q <= state_d;
			strobe_q <= strobe_d;
		end
	end

	always_ff @(posedge clk) begin
		bin_q <= bin_d;
		bcd_q <= bcd_d;
		cnt_q <= cnt_d;
		neg_q <= neg_d;
		pos_q <= pos_d;
		idx_q <= idx_d;
		out_pos_q <= out_pos_d;
		out_seg_q <= out_seg_d;
		out_last_q <= out_last_d;
	end

	assign busy = (state_q != d7s_pkg::ST_IDLE);
	assign strobe = strobe_q;
	assign digit_position = out_pos_q;
	assign segment_pattern = out_seg_q;
	assign last = out_last_q;

	// Characters of one number come out in consecutive cycles.
	a_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last |=> strobe)
		else $error("character stream broke before the final character");

	// The final character is followed by a gap.
	a_gap_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && last |=> !strobe)
		else $error("character emitted after the final one");

	// An accepted request makes the block busy.
	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("request accepted but block not busy");

	// Positions advance by one within a number.
	a_pos_step: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last |=> digit_position == $past(digit_position) + 8'd1)
		else $error("display position did not advance by one");

endmodule

FILE: dv/tb.sv
// Testbench for the decimal to seven-segment writer: directed table, then random requests.
`timescale 1ns / 100ps

module tb;

	typedef struct packed {
		logic [7:0] pos;
		logic [7:0] pattern;
		logic       last;
	} glyph_t;

	typedef struct packed {
		logic        kind;
		logic [15:0] value;
		logic [7:0]  pos;
		logic [2:0]  n_typed;
		logic [47:0] typed_glyphs;
	} dir_row_t;

	localparam logic [7:0] GlyphDigit [10] = '{
		8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F
	};
	localparam logic [7:0] GlyphMinus = 8'h40;
	localparam logic KindUnsigned = 1'b0;
	localparam logic KindSigned = 1'b1;
	localparam int RandomCount = 176;
	localparam int QuietTail = 30;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        kind = 1'b0;
	logic [15:0] value = 16'd0;
	logic [7:0]  start_position = 8'd0;
	logic        busy;
	logic        strobe;
	logic [7:0]  digit_position;
	logic [7:0]  segment_pattern;
	logic        last;

	glyph_t pending_glyphs [$];
	int     mismatch_count = 0;
	bit     idling_on = 1'b1;

	// Rows with a glyph count carry their expected patterns; the rest go to the predictor.
	dir_row_t dir_rows [] = '{
		{KindUnsigned, 16'h0000, 8'd0,   3'd1, 48'h3F0000000000},
		{KindSigned,   16'h0000, 8'd255, 3'd1, 48'h3F0000000000},
		{KindUnsigned, 16'hFFFF, 8'd0,   3'd5, 48'h7D6D6D4F6D00},
		{KindSigned,   16'h8000, 8'd252, 3'd6, 48'h404F5B077D7F},
		{KindSigned,   16'hFFFF, 8'd255, 3'd2, 48'h400600000000},
		{KindSigned,   16'h7FFF, 8'd10,  3'd5, 48'h4F5B077D0700},
		{KindUnsigned, 16'h8000, 8'd128, 3'd5, 48'h4F5B077D7F00},
		{KindUnsigned, 16'd9,     8'd254, 3'd0, 48'h0},
		{KindUnsigned, 16'd10,    8'd3,   3'd0, 48'h0},
		{KindUnsigned, 16'd99,    8'd77,  3'd0, 48'h0},
		{KindUnsigned, 16'd100,   8'd200, 3'd0, 48'h0},
		{KindUnsigned, 16'd999,   8'd253, 3'd0, 48'h0},
		{KindUnsigned, 16'd1000,  8'd1,   3'd0, 48'h0},
		{KindUnsigned, 16'd9999,  8'd64,  3'd0, 48'h0},
		{KindUnsigned, 16'd10000, 8'd251, 3'd0, 48'h0},
		{KindUnsigned, 16'd12345, 8'd170, 3'd0, 48'h0},
		{KindUnsigned, 16'd36789, 8'd85,  3'd0, 48'h0},
		{KindSigned,   16'hFFF6,  8'd250, 3'd0, 48'h0},
		{KindSigned,   16'h8001,  8'd0,   3'd0, 48'h0},
		{KindSigned,   16'hAAAA,  8'd255, 3'd0, 48'h0},
		{KindSigned,   16'h5555,  8'd170, 3'd0, 48'h0},
		{KindSigned,   16'h0001,  8'd85,  3'd0, 48'h0},
		{KindUnsigned, 16'h5555,  8'd15,  3'd0, 48'h0},
		{KindUnsigned, 16'hAAAA,  8'd240, 3'd0, 48'h0}
	};

	decimal_to_seven_segment dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.kind           (kind),
		.value          (value),
		.start_position (start_position),
		.strobe         (strobe),
		.digit_position (digit_position),
		.segment_pattern(segment_pattern),
		.last           (last)
	);

	always #5 clk = ~clk;

	function automatic void predict_glyphs(input logic k, input logic [15:0] v,
		input logic [7:0] p);
		logic        negative;
		logic [16:0] magnitude;
		logic [3:0]  digits [5];
		logic [7:0]  at;
		int          n_digits;
		int          total;
		int          idx;
		negative = k && v[15];
		magnitude = negative ? (17'h10000 - {1'b0, v}) : {1'b0, v};
		n_digits = 0;
		do begin
			digits[n_digits] = 4'(magnitude % 10);
			magnitude = magnitude / 10;
			n_digits++;
		end while (magnitude != 0 && n_digits < 5);
		total = n_digits + (negative ? 1 : 0);
		at = p;
		idx = 0;
		if (negative) begin
			pending_glyphs.push_back('{at, GlyphMinus, idx == total - 1});
			idx++;
			at++;
		end
		for (int i = n_digits - 1; i >= 0; i--) begin
			pending_glyphs.push_back('{at, GlyphDigit[digits[i]], idx == total - 1});
			idx++;
			at++;
		end
	endfunction

	// Holds the request until the block takes it; start may drop for short bursts meanwhile.
	task automatic send_request(input logic k, input logic [15:0] v, input logic [7:0] p);
		bit taken;
		kind <= k;
		value <= v;
		start_position <= p;
		start <= 1'b1;
		taken = 1'b0;
		while (!taken) begin
			@(posedge clk);
			if (!busy) begin
				taken = 1'b1;
			end else if (idling_on && $urandom_range(0, 3) == 0) begin
				start <= 1'b0;
				repeat ($urandom_range(1, 3)) @(posedge clk);
				start <= 1'b1;
			end
		end
	endtask

	task automatic maybe_idle();
		if (idling_on && $urandom_range(0, 2) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
	endtask

	always @(posedge clk) begin : check_glyphs
		glyph_t want;
		if (arst_n && strobe !== 1'b0) begin
			if (pending_glyphs.size() == 0) begin
				$error("strobe: expected 0, actual %b", strobe);
				mismatch_count++;
			end else begin
				want = pending_glyphs.pop_front();
				if (digit_position !== want.pos) begin
					$error("digit_position: expected %0d, actual %0d", want.pos, digit_position);
					mismatch_count++;
				end
				if (segment_pattern !== want.pattern) begin
					$error("segment_pattern: expected %h, actual %h", want.pattern,
						segment_pattern);
					mismatch_count++;
				end
				if (last !== want.last) begin
					$error("last: expected %b, actual %b", want.last, last);
					mismatch_count++;
				end
			end
		end
	end

	initial begin
		logic        k;
		logic [15:0] v;
		logic [7:0]  p;
		int          pick;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		if (busy !== 1'b0) begin
			$error("busy: expected 0, actual %b", busy);
			mismatch_count++;
		end
		if (strobe !== 1'b0) begin
			$error("strobe: expected 0, actual %b", strobe);
			mismatch_count++;
		end

		foreach (dir_rows[r]) begin
			maybe_idle();
			send_request(dir_rows[r].kind, dir_rows[r].value, dir_rows[r].pos);
			if (dir_rows[r].n_typed == 0) begin
				predict_glyphs(dir_rows[r].kind, dir_rows[r].value, dir_rows[r].pos);
			end else begin
				for (int i = 0; i < dir_rows[r].n_typed; i++) begin
					pending_glyphs.push_back('{dir_rows[r].pos + 8'(i),
						dir_rows[r].typed_glyphs[47 - 8 * i -: 8],
						i == dir_rows[r].n_typed - 1});
				end
			end
		end

		for (int n = 0; n < RandomCount; n++) begin
			if (n == RandomCount - QuietTail) begin
				idling_on = 1'b0;
			end
			k = 1'($urandom_range(0, 1));
			pick = $urandom_range(0, 7);
			case (pick)
				0, 1: begin
					v = 16'($urandom_range(0, 99));
				end
				2: begin
					case ($urandom_range(0, 4))
						0: v = 16'h0000;
						1: v = 16'h7FFF;
						2: v = 16'h8000;
						3: v = 16'h8001;
						default: v = 16'hFFFF;
					endcase
				end
				3: begin
					v = 16'hFFFF - 16'($urandom_range(0, 99));
				end
				default: begin
					v = 16'($urandom);
				end
			endcase
			p = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(250, 255)) : 8'($urandom);
			maybe_idle();
			send_request(k, v, p);
			predict_glyphs(k, v, p);
		end
		start <= 1'b0;

		while (pending_glyphs.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	initial begin
		#2ms;
		$display("Mismatches found");
		$finish;
	end

endmodule
